@@ rtl/steq_pkg.sv @@
package steq_pkg;

    // configuration port
    localparam int REG_W     = 18;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] CFG_PREAMP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] CFG_LOW_COEF  = 3'd1;
    localparam logic [REG_IDX_W-1:0] CFG_HIGH_COEF = 3'd2;
    localparam logic [REG_IDX_W-1:0] CFG_LOW_GAIN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] CFG_MID_GAIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] CFG_HIGH_GAIN = 3'd5;

    localparam logic [REG_W-1:0] RST_PREAMP    = 18'd65536;
    localparam logic [REG_W-1:0] RST_LOW_COEF  = 18'd3419;
    localparam logic [REG_W-1:0] RST_HIGH_COEF = 18'd46626;
    localparam logic [REG_W-1:0] RST_GAIN      = 18'd65536;

    // default geometry
    localparam int SAMPLE_WIDTH_DEF = 20;
    localparam int STATE_WIDTH_DEF  = 32;
    localparam int MUL_A_W_DEF      = 33;

    // fixed point
    localparam int OUT_W      = 16;
    localparam int FRAC_BITS  = 24;
    localparam int COEF_FRAC  = 16;
    localparam int PRE_SHIFT  = 8;
    localparam int POLES      = 4;
    localparam int HIST_DEPTH = 3;

    // soft clipper
    localparam int MUL_B_W  = 27;              // clip input, |s| <= 3.0 in Q.24
    localparam int SQ_W     = 28;              // s^2 in Q.24
    localparam int T_W      = 31;              // 27 + x2 and 27 + 9*x2
    localparam int NUM_W    = 56;              // |s * (27 + x2)|
    localparam int QUO_W    = 27;
    localparam int CLIP_LIM = 3 << FRAC_BITS;
    localparam logic [T_W-1:0] K27 = 31'(27 << FRAC_BITS);
    localparam int OUT_MAX  = 32767;
    localparam int SCALE_SHIFT = 15;           // 32767 = 2^15 - 1

endpackage

@@ rtl/steq_mul.sv @@
module steq_mul #(
    parameter int A_W = steq_pkg::MUL_A_W_DEF,
    parameter int B_W = steq_pkg::MUL_B_W
) (
    input  logic                   i_clk,
    input  logic signed [A_W-1:0]  i_a,
    input  logic signed [B_W-1:0]  i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/steq_div.sv @@
module steq_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [steq_pkg::NUM_W-1:0]    i_dividend,
    input  logic [steq_pkg::T_W-1:0]      i_divisor,
    output logic                          o_done,
    output logic [steq_pkg::QUO_W-1:0]    o_quot
);

    import steq_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [T_W:0]     r_rem;
    logic [QUO_W-1:0] r_low;
    logic [QUO_W-1:0] r_quot;
    logic [T_W-1:0]   r_div;

    logic [T_W:0]     n_shift;
    logic             n_fit;

    // restoring step, one quotient bit per cycle
    assign n_shift = {r_rem[T_W-1:0], r_low[QUO_W-1]};
    assign n_fit   = n_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= (T_W+1)'(i_dividend[NUM_W-1:QUO_W]);
                r_low  <= i_dividend[QUO_W-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_fit ? n_shift - {1'b0, r_div} : n_shift;
                r_low  <= {r_low[QUO_W-2:0], 1'b0};
                r_quot <= {r_quot[QUO_W-2:0], n_fit};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/stereo_three_band_equalizer.sv @@
// Stereo three-band equalizer with soft clipper. Samples arrive interleaved, left first;
// last_of_block sends the next sample back to the left channel. One sample is processed
// at a time by a sequencer around a single shared multiplier and a radix-2 divider: the
// eight pole updates each run through a difference, a multiply and an accumulate state,
// and the squaring and the 27-step division are skipped when the band sum lies beyond
// the clip limit. in_ready is high only while the sequencer is idle, so the next sample
// can be taken in the cycle after a result is loaded; a finished result waits in the
// output register while the next sample is taken in. Configuration writes take effect
// at once and belong in idle periods.
module stereo_three_band_equalizer #(
    parameter int SAMPLE_WIDTH = steq_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = steq_pkg::STATE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_in_sample,
    input  logic                              i_last_of_block,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [steq_pkg::OUT_W-1:0] o_out_sample,
    output logic                              o_out_channel,
    input  logic                              i_cfg_we,
    input  logic [steq_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input  logic [steq_pkg::REG_W-1:0]        i_cfg_data
);

    import steq_pkg::*;

    localparam int W    = STATE_WIDTH;
    localparam int DW   = W + 1;
    localparam int AW   = W + 5;
    localparam int MA0  = (DW > T_W) ? DW : T_W;
    localparam int MA   = (SAMPLE_WIDTH > MA0) ? SAMPLE_WIDTH : MA0;
    localparam int PW   = MA + MUL_B_W;
    localparam int SATW = PW + 1;
    localparam int NP   = 2 * 2 * POLES;
    localparam int PIDX_W = $clog2(NP);
    localparam int K_W  = $clog2(POLES);
    localparam int SC_W = QUO_W + SCALE_SHIFT;
    localparam int MAG_W = SC_W - FRAC_BITS;

    localparam logic [K_W-1:0] K_LAST = K_W'(POLES - 1);
    localparam logic signed [AW-1:0] CLIP_HI = AW'(CLIP_LIM);
    localparam logic signed [AW-1:0] CLIP_LO = -CLIP_HI;
    localparam logic [OUT_W-1:0] MAG_MAX = OUT_W'(OUT_MAX);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_PRE     = 5'd1;
    localparam logic [4:0] S_PRE_SAT = 5'd2;
    localparam logic [4:0] S_P_DIFF  = 5'd3;
    localparam logic [4:0] S_P_MUL   = 5'd4;
    localparam logic [4:0] S_P_ACC   = 5'd5;
    localparam logic [4:0] S_BANDS   = 5'd6;
    localparam logic [4:0] S_G_LOW   = 5'd7;
    localparam logic [4:0] S_G_MID   = 5'd8;
    localparam logic [4:0] S_G_HIGH  = 5'd9;
    localparam logic [4:0] S_G_ACC   = 5'd10;
    localparam logic [4:0] S_C_CHK   = 5'd11;
    localparam logic [4:0] S_C_SQ    = 5'd12;
    localparam logic [4:0] S_C_DEN   = 5'd13;
    localparam logic [4:0] S_C_NUM   = 5'd14;
    localparam logic [4:0] S_C_DIVS  = 5'd15;
    localparam logic [4:0] S_C_DIV   = 5'd16;
    localparam logic [4:0] S_C_SCALE = 5'd17;
    localparam logic [4:0] S_FIN     = 5'd18;

    function automatic logic signed [W-1:0] f_sat(input logic signed [SATW-1:0] v);
        logic [SATW-W:0] top;
        top = v[SATW-1:W-1];
        if (&top || ~|top) begin
            return v[W-1:0];
        end
        return v[SATW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    logic [4:0]                   r_state;
    logic [REG_W-1:0]             r_preamp;
    logic [REG_W-1:0]             r_low_coef;
    logic [REG_W-1:0]             r_high_coef;
    logic [REG_W-1:0]             r_low_gain;
    logic [REG_W-1:0]             r_mid_gain;
    logic [REG_W-1:0]             r_high_gain;

    logic signed [W-1:0]          r_pole [NP];
    logic signed [W-1:0]          r_hist [2*HIST_DEPTH];
    logic                         r_toggle;

    logic signed [SAMPLE_WIDTH-1:0] r_in;
    logic                         r_last;
    logic                         r_ch;
    logic                         r_band;
    logic [K_W-1:0]               r_k;
    logic signed [W-1:0]          r_sample;
    logic signed [W-1:0]          r_x;
    logic signed [W-1:0]          r_l;
    logic signed [DW-1:0]         r_diff;
    logic signed [DW-1:0]         r_m;
    logic signed [DW-1:0]         r_h;
    logic signed [AW-1:0]         r_acc;
    logic signed [MUL_B_W-1:0]    r_s;
    logic                         r_neg;
    logic [T_W-1:0]               r_t;
    logic [T_W-1:0]               r_den;
    logic [OUT_W-1:0]             r_mag;

    logic                         r_out_valid;
    logic signed [OUT_W-1:0]      r_out_sample;
    logic                         r_out_channel;

    logic signed [MA-1:0]         n_a;
    logic signed [MUL_B_W-1:0]    n_b;
    logic signed [PW-1:0]         prod;
    logic [PIDX_W-1:0]            pole_idx;
    logic signed [W-1:0]          pole_rd;
    logic signed [W-1:0]          n_pole;
    logic signed [W-1:0]          d3;
    logic [SQ_W-1:0]              x2;
    logic signed [PW-1:0]         num_abs;
    logic                         div_start;
    logic                         div_done;
    logic [QUO_W-1:0]             quot;
    logic [SC_W-1:0]              scaled;
    logic [MAG_W-1:0]             mag_full;
    logic                         out_load;

    assign pole_idx = {r_band, r_ch, r_k};
    assign pole_rd  = r_pole[pole_idx];
    assign n_pole   = f_sat(SATW'(pole_rd) + SATW'(prod >>> COEF_FRAC));
    assign d3       = r_ch ? r_hist[2*HIST_DEPTH-1] : r_hist[HIST_DEPTH-1];
    assign x2       = prod[FRAC_BITS+SQ_W-1:FRAC_BITS];
    assign num_abs  = r_neg ? -prod : prod;
    assign div_start = (r_state == S_C_DIVS);
    assign scaled   = {quot, {SCALE_SHIFT{1'b0}}} - SC_W'(quot);
    assign mag_full = scaled[SC_W-1:FRAC_BITS];
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_a = '0;
        n_b = '0;
        unique case (r_state)
            S_PRE: begin
                n_a = MA'(r_in);
                n_b = MUL_B_W'(r_preamp);
            end
            S_P_MUL: begin
                n_a = MA'(r_diff);
                n_b = MUL_B_W'(r_band ? r_high_coef : r_low_coef);
            end
            S_G_LOW: begin
                n_a = MA'(r_l);
                n_b = MUL_B_W'(r_low_gain);
            end
            S_G_MID: begin
                n_a = MA'(r_m);
                n_b = MUL_B_W'(r_mid_gain);
            end
            S_G_HIGH: begin
                n_a = MA'(r_h);
                n_b = MUL_B_W'(r_high_gain);
            end
            S_C_SQ: begin
                n_a = MA'(r_s);
                n_b = r_s;
            end
            S_C_NUM: begin
                n_a = MA'(r_t);
                n_b = r_s;
            end
            default: begin
                n_a = '0;
                n_b = '0;
            end
        endcase
    end

    steq_mul #(
        .A_W (MA),
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (n_a),
        .i_b    (n_b),
        .o_prod (prod)
    );

    steq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_abs[NUM_W-1:0]),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_preamp    <= RST_PREAMP;
            r_low_coef  <= RST_LOW_COEF;
            r_high_coef <= RST_HIGH_COEF;
            r_low_gain  <= RST_GAIN;
            r_mid_gain  <= RST_GAIN;
            r_high_gain <= RST_GAIN;
            for (int i = 0; i < NP; i++) begin
                r_pole[i] <= '0;
            end
            for (int i = 0; i < 2*HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_toggle    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PREAMP:    r_preamp    <= i_cfg_data;
                    CFG_LOW_COEF:  r_low_coef  <= i_cfg_data;
                    CFG_HIGH_COEF: r_high_coef <= i_cfg_data;
                    CFG_LOW_GAIN:  r_low_gain  <= i_cfg_data;
                    CFG_MID_GAIN:  r_mid_gain  <= i_cfg_data;
                    CFG_HIGH_GAIN: r_high_gain <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_sample;
                        r_last  <= i_last_of_block;
                        r_ch    <= r_toggle;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_state <= S_PRE_SAT;
                end
                S_PRE_SAT: begin
                    r_sample <= f_sat(SATW'(prod >>> PRE_SHIFT));
                    r_x      <= f_sat(SATW'(prod >>> PRE_SHIFT));
                    r_band   <= 1'b0;
                    r_k      <= '0;
                    r_state  <= S_P_DIFF;
                end
                S_P_DIFF: begin
                    r_diff  <= DW'(r_x) - DW'(pole_rd);
                    r_state <= S_P_MUL;
                end
                S_P_MUL: begin
                    r_state <= S_P_ACC;
                end
                S_P_ACC: begin
                    r_pole[pole_idx] <= n_pole;
                    r_k <= r_k + 1'b1;
                    if (r_k != K_LAST) begin
                        r_x     <= n_pole;
                        r_state <= S_P_DIFF;
                    end else if (!r_band) begin
                        r_l     <= n_pole;
                        r_x     <= r_sample;
                        r_band  <= 1'b1;
                        r_state <= S_P_DIFF;
                    end else begin
                        r_x     <= n_pole;
                        r_state <= S_BANDS;
                    end
                end
                S_BANDS: begin
                    // x holds the last high pole here
                    r_h <= DW'(d3) - DW'(r_x);
                    r_m <= DW'(r_x) - DW'(r_l);
                    for (int c = 0; c < 2; c++) begin
                        if (r_ch == 1'(c)) begin
                            for (int j = HIST_DEPTH - 1; j > 0; j--) begin
                                r_hist[c*HIST_DEPTH+j] <= r_hist[c*HIST_DEPTH+j-1];
                            end
                            r_hist[c*HIST_DEPTH] <= r_sample;
                        end
                    end
                    r_state <= S_G_LOW;
                end
                S_G_LOW: begin
                    r_state <= S_G_MID;
                end
                S_G_MID: begin
                    r_acc   <= AW'(prod >>> COEF_FRAC);
                    r_state <= S_G_HIGH;
                end
                S_G_HIGH: begin
                    r_acc   <= r_acc + AW'(prod >>> COEF_FRAC);
                    r_state <= S_G_ACC;
                end
                S_G_ACC: begin
                    r_acc   <= r_acc + AW'(prod >>> COEF_FRAC);
                    r_state <= S_C_CHK;
                end
                S_C_CHK: begin
                    if (r_acc > CLIP_HI) begin
                        r_neg   <= 1'b0;
                        r_mag   <= MAG_MAX;
                        r_state <= S_FIN;
                    end else if (r_acc < CLIP_LO) begin
                        r_neg   <= 1'b1;
                        r_mag   <= MAG_MAX;
                        r_state <= S_FIN;
                    end else begin
                        r_s     <= r_acc[MUL_B_W-1:0];
                        r_neg   <= r_acc[AW-1];
                        r_state <= S_C_SQ;
                    end
                end
                S_C_SQ: begin
                    r_state <= S_C_DEN;
                end
                S_C_DEN: begin
                    r_t     <= K27 + T_W'(x2);
                    r_den   <= K27 + T_W'({x2, 3'b000}) + T_W'(x2);
                    r_state <= S_C_NUM;
                end
                S_C_NUM: begin
                    r_state <= S_C_DIVS;
                end
                S_C_DIVS: begin
                    r_state <= S_C_DIV;
                end
                S_C_DIV: begin
                    if (div_done) begin
                        r_state <= S_C_SCALE;
                    end
                end
                S_C_SCALE: begin
                    r_mag   <= (mag_full > MAG_W'(OUT_MAX)) ? MAG_MAX : OUT_W'(mag_full);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_sample  <= r_neg ? -r_mag : r_mag;
                        r_out_channel <= r_ch;
                        r_toggle      <= r_last ? 1'b0 : ~r_ch;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_out_channel = r_out_channel;

endmodule
